@@ hw/rtl/tfll_pkg.sv @@
// Shared constants, codes and transfer types of the timestamped frame log lookup unit.
package tfll_pkg;

   // Log geometry.
   localparam int LOG_DEPTH = 1024;
   localparam int ADDR_W    = $clog2(LOG_DEPTH);
   localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

   // Field widths.
   localparam int TIME_W   = 64;
   localparam int FRAME_W  = 56;
   localparam int HEADER_W = 8;
   localparam int STATUS_W = 2;

   // Header values.
   localparam logic [HEADER_W-1:0] HEADER_LOOKUP = 8'd85;
   localparam logic [HEADER_W-1:0] HEADER_NONE   = 8'd0;

   // Command codes.
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // One input item.
   typedef struct packed {
      logic               cmd;
      logic [TIME_W-1:0]  time_req;
      logic [FRAME_W-1:0] frame_in;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [HEADER_W-1:0] header_byte;
      logic [FRAME_W-1:0]  frame_out;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Access request from the sequencer to the log memories.
   typedef struct packed {
      logic [ADDR_W-1:0]  rd_addr;
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [TIME_W-1:0]  wr_time;
      logic [FRAME_W-1:0] wr_frame;
   } mem_cmd_type;

endpackage

@@ hw/rtl/timestamped_frame_log_lookup_unit.sv @@
// Top level of the timestamped frame log lookup unit.
//
//   Channel   Ports                      Transfer when
//   request   start, busy, req_data      start high and busy low at a rising edge
//   result    rsp_strobe, rsp_data       rsp_strobe high (one cycle, no stall)
//
// Append: on an empty log the frame is stored at once; otherwise one read of
// the last stored frame for the duplicate check, then the write.
// Lookup: an empty log answers at once; otherwise a binary search runs, one
// halving step per cycle on the single read port, then a read of the found entry.
// Synchronous reset empties the log at once; stored entries are not cleared.
// busy stays high until the result is formed; results cannot be held off.
module timestamped_frame_log_lookup_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tfll_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tfll_pkg::rsp_type rsp_data
);
   import tfll_pkg::*;

   mem_cmd_type        mem_cmd;
   logic [TIME_W-1:0]  rd_time;
   logic [FRAME_W-1:0] rd_frame;

   // Sequencer.
   tfll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .mem_cmd    (mem_cmd),
      .rd_time    (rd_time),
      .rd_frame   (rd_frame)
   );

   // Log storage.
   tfll_log_mem u_log_mem (
      .clock    (clock),
      .mem_cmd  (mem_cmd),
      .rd_time  (rd_time),
      .rd_frame (rd_frame)
   );

endmodule

@@ hw/rtl/tfll_log_mem.sv @@
// Time and frame log memories with one write port and one registered read port.
module tfll_log_mem (
   input  logic                          clock,
   input  tfll_pkg::mem_cmd_type         mem_cmd,
   output logic [tfll_pkg::TIME_W-1:0]   rd_time,
   output logic [tfll_pkg::FRAME_W-1:0]  rd_frame
);
   import tfll_pkg::*;

   logic [TIME_W-1:0]  time_mem  [LOG_DEPTH];
   logic [FRAME_W-1:0] frame_mem [LOG_DEPTH];
   logic [TIME_W-1:0]  rd_time_ff;
   logic [FRAME_W-1:0] rd_frame_ff;

   // Write the entry on request.
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         time_mem[mem_cmd.wr_addr]  <= mem_cmd.wr_time;
         frame_mem[mem_cmd.wr_addr] <= mem_cmd.wr_frame;
      end
   end

   // Read both fields of one entry every cycle; the data is registered and shows in the next cycle.
   always_ff @(posedge clock) begin
      rd_time_ff  <= time_mem[mem_cmd.rd_addr];
      rd_frame_ff <= frame_mem[mem_cmd.rd_addr];
   end

   assign rd_time  = rd_time_ff;
   assign rd_frame = rd_frame_ff;

endmodule

@@ hw/rtl/tfll_ctrl.sv @@
// Sequencer for append with duplicate check and binary-search lookup over the log.
module tfll_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  tfll_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output tfll_pkg::rsp_type             rsp_data,
   output tfll_pkg::mem_cmd_type         mem_cmd,
   input  logic [tfll_pkg::TIME_W-1:0]   rd_time,
   input  logic [tfll_pkg::FRAME_W-1:0]  rd_frame
);
   import tfll_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DUP    = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_FETCH  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [TIME_W-1:0]  key_time_ff, key_time_in;
   logic [FRAME_W-1:0] key_frame_ff, key_frame_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic [CNT_W-1:0]   last_idx;
   logic [CNT_W-1:0]   lo_step, hi_step, span_step, mid_step, mid_first;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   assign last_idx  = count_ff - CNT_W'(1);
   assign mid_first = count_ff >> 1;

   // One halving step: the read data belongs to the entry at mid_ff.
   assign lo_step   = (rd_time > key_time_ff) ? lo_ff  : mid_ff;
   assign hi_step   = (rd_time > key_time_ff) ? mid_ff : hi_ff;
   assign span_step = hi_step - lo_step;
   assign mid_step  = lo_step + (span_step >> 1);

   // Next-state and memory access logic.
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      mid_in           = mid_ff;
      key_time_in      = key_time_ff;
      key_frame_in     = key_frame_ff;
      rsp_strobe_in    = 1'b0;
      rsp_in           = rsp_ff;
      mem_cmd.rd_addr  = '0;
      mem_cmd.wr_en    = 1'b0;
      mem_cmd.wr_addr  = count_ff[ADDR_W-1:0];
      mem_cmd.wr_time  = key_time_ff;
      mem_cmd.wr_frame = key_frame_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_time_in  = req_data.time_req;
               key_frame_in = req_data.frame_in;
               if (req_data.cmd == CMD_APPEND) begin
                  if (count_ff == '0) begin
                     // Empty log: store at once, no duplicate to check.
                     mem_cmd.wr_en    = 1'b1;
                     mem_cmd.wr_addr  = '0;
                     mem_cmd.wr_time  = req_data.time_req;
                     mem_cmd.wr_frame = req_data.frame_in;
                     count_in         = CNT_W'(1);
                     rsp_strobe_in    = 1'b1;
                     rsp_in.header_byte = HEADER_NONE;
                     rsp_in.frame_out   = '0;
                     rsp_in.status      = ST_OK;
                  end else begin
                     mem_cmd.rd_addr = last_idx[ADDR_W-1:0];
                     state_in        = S_DUP;
                  end
               end else begin
                  lo_in = '0;
                  hi_in = count_ff;
                  if (count_ff == '0) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_in.header_byte = HEADER_LOOKUP;
                     rsp_in.frame_out   = '0;
                     rsp_in.status      = ST_EMPTY;
                  end else if (count_ff == CNT_W'(1)) begin
                     mem_cmd.rd_addr = '0;
                     state_in        = S_FETCH;
                  end else begin
                     mid_in          = mid_first;
                     mem_cmd.rd_addr = mid_first[ADDR_W-1:0];
                     state_in        = S_SEARCH;
                  end
               end
            end
         end
         S_DUP: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.header_byte = HEADER_NONE;
            rsp_in.frame_out   = '0;
            state_in           = S_IDLE;
            if (rd_frame == key_frame_ff) begin
               rsp_in.status = ST_DUP;
            end else if (count_ff == CNT_W'(LOG_DEPTH)) begin
               rsp_in.status = ST_FULL;
            end else begin
               mem_cmd.wr_en = 1'b1;
               count_in      = count_ff + CNT_W'(1);
               rsp_in.status = ST_OK;
            end
         end
         S_SEARCH: begin
            lo_in = lo_step;
            hi_in = hi_step;
            if (span_step > CNT_W'(1)) begin
               mid_in          = mid_step;
               mem_cmd.rd_addr = mid_step[ADDR_W-1:0];
            end else begin
               mem_cmd.rd_addr = lo_step[ADDR_W-1:0];
               state_in        = S_FETCH;
            end
         end
         S_FETCH: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.header_byte = HEADER_LOOKUP;
            rsp_in.frame_out   = rd_frame;
            rsp_in.status      = ST_OK;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Search bounds, request key and result payload.
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_time_ff  <= key_time_in;
      key_frame_ff <= key_frame_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // The log never holds more entries than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LOG_DEPTH))
      else $error("entry count beyond log depth");

   // While searching, the window stays open and inside the stored entries.
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> ((hi_ff - lo_ff) > CNT_W'(1)) && (hi_ff <= count_ff)
         && (mid_ff > lo_ff) && (mid_ff < hi_ff))
      else $error("search window out of range");

   // A write lands only on the next free entry of a log with room.
   a_write_slot: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |-> ((mem_cmd.wr_addr == count_ff[ADDR_W-1:0])
         && (count_ff < CNT_W'(LOG_DEPTH))) ##1 (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("log write outside the free entry");

   // Every accepted transfer either starts work or answers in the next cycle.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("accepted transfer dropped");

   // A result is only presented once the sequencer is back at rest.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == S_IDLE))
      else $error("result while sequencer busy");

endmodule
